>>> hw/rtl/nnis_pkg.sv
// Shared types and constants for the nearest-neighbor image scaler.
// No dependencies; the core, nnis_front and nnis_back refer to this package by scoped names.
package nnis_pkg;

  // Fixed field widths of the pixel and size registers.
  localparam int BYTES_PER_PIXEL = 3;
  localparam int PIX_W           = BYTES_PER_PIXEL * 8;
  localparam int SZ_IN_W         = 10;
  localparam int SZ_OUT_W        = 13;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Item kinds carried on in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Register indexes, taken from cfg_paddr[3:2].
  localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

  // Reset values of the size registers.
  localparam logic [SZ_IN_W-1:0]  RST_IN_SIZE  = SZ_IN_W'(512);
  localparam logic [SZ_OUT_W-1:0] RST_OUT_SIZE = SZ_OUT_W'(512);

  // Effective (clamped) image sizes, shared by the front and the back.
  typedef struct packed {
    logic [SZ_IN_W-1:0]  in_width;
    logic [SZ_IN_W-1:0]  in_height;
    logic [SZ_OUT_W-1:0] out_width;
    logic [SZ_OUT_W-1:0] out_height;
  } sizes_t;

endpackage

>>> hw/rtl/nearest_neighbour_image_scaler_core.sv
// A load is written into the store at the edge that takes it from the queue; an emit
// walks the back through its multiply, divide, address, read and output states before its
// pixel shows, the coordinate dividers (NUM_W bits wide, the output counter width plus 10)
// retiring one quotient bit per cycle. The back retires one load per cycle while in its
// fetch state, takes no new entry during an emit, and waits while out_tready stays low.
// Reset (synchronous, active low) clears positions, queue and handshakes and sets all size
// registers to 512; the frame store is not cleared, so pixels must be loaded before use.
//
// Top level of the nearest-neighbor image scaler: config registers, front, queue, back.
// Depends on nnis_pkg, nnis_front, nnis_fifo, nnis_div and nnis_back.
module nearest_neighbour_image_scaler_core #(
  parameter int MAX_IN_WIDTH  = 512,
  parameter int MAX_IN_HEIGHT = 512,
  parameter int MAX_OUT_SIZE  = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [nnis_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  // in_tdata fields from bit 0: red, green, blue
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nnis_pkg::PIX_W-1:0]          in_tdata,
  // in_tuser fields from bit 0: operation
  input  logic                                in_tuser,
  // out_tdata fields from bit 0: out_red, out_green, out_blue
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nnis_pkg::PIX_W-1:0]          out_tdata,
  // out_tlast carries frame_end
  output logic                                out_tlast
);

  localparam int STORE_DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int OC_W        = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
  localparam int ENTRY_W     = 2*OC_W + ADDR_W + nnis_pkg::PIX_W + 2;
  localparam int QCNT_W      = $clog2(nnis_pkg::QUEUE_DEPTH + 1);

  logic [nnis_pkg::SZ_IN_W-1:0]  in_width_r;
  logic [nnis_pkg::SZ_IN_W-1:0]  in_height_r;
  logic [nnis_pkg::SZ_OUT_W-1:0] out_width_r;
  logic [nnis_pkg::SZ_OUT_W-1:0] out_height_r;
  logic [1:0]                    reg_idx;
  logic                          cfg_wr;
  nnis_pkg::sizes_t              sizes;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_empty;
  logic [ENTRY_W-1:0]            q_wdata;
  logic [ENTRY_W-1:0]            q_rdata;
  logic [QCNT_W-1:0]             q_count;

  // Register file access.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= nnis_pkg::RST_IN_SIZE;
      in_height_r  <= nnis_pkg::RST_IN_SIZE;
      out_width_r  <= nnis_pkg::RST_OUT_SIZE;
      out_height_r <= nnis_pkg::RST_OUT_SIZE;
    end else if (cfg_wr) begin
      case (reg_idx)
        nnis_pkg::REG_IN_WIDTH:   in_width_r   <= cfg_pwdata[nnis_pkg::SZ_IN_W-1:0];
        nnis_pkg::REG_IN_HEIGHT:  in_height_r  <= cfg_pwdata[nnis_pkg::SZ_IN_W-1:0];
        nnis_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_pwdata[nnis_pkg::SZ_OUT_W-1:0];
        nnis_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_pwdata[nnis_pkg::SZ_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nnis_pkg::REG_IN_WIDTH:   cfg_prdata = nnis_pkg::CFG_DATA_W'(in_width_r);
      nnis_pkg::REG_IN_HEIGHT:  cfg_prdata = nnis_pkg::CFG_DATA_W'(in_height_r);
      nnis_pkg::REG_OUT_WIDTH:  cfg_prdata = nnis_pkg::CFG_DATA_W'(out_width_r);
      nnis_pkg::REG_OUT_HEIGHT: cfg_prdata = nnis_pkg::CFG_DATA_W'(out_height_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // Effective sizes: zero reads as one, anything above the maximum saturates.
  always_comb begin
    sizes.in_width = in_width_r;
    if (in_width_r == '0) begin
      sizes.in_width = nnis_pkg::SZ_IN_W'(1);
    end else if (32'(in_width_r) > 32'(MAX_IN_WIDTH)) begin
      sizes.in_width = nnis_pkg::SZ_IN_W'(MAX_IN_WIDTH);
    end
    sizes.in_height = in_height_r;
    if (in_height_r == '0) begin
      sizes.in_height = nnis_pkg::SZ_IN_W'(1);
    end else if (32'(in_height_r) > 32'(MAX_IN_HEIGHT)) begin
      sizes.in_height = nnis_pkg::SZ_IN_W'(MAX_IN_HEIGHT);
    end
    sizes.out_width = out_width_r;
    if (out_width_r == '0) begin
      sizes.out_width = nnis_pkg::SZ_OUT_W'(1);
    end else if (32'(out_width_r) > 32'(MAX_OUT_SIZE)) begin
      sizes.out_width = nnis_pkg::SZ_OUT_W'(MAX_OUT_SIZE);
    end
    sizes.out_height = out_height_r;
    if (out_height_r == '0) begin
      sizes.out_height = nnis_pkg::SZ_OUT_W'(1);
    end else if (32'(out_height_r) > 32'(MAX_OUT_SIZE)) begin
      sizes.out_height = nnis_pkg::SZ_OUT_W'(MAX_OUT_SIZE);
    end
  end

  nnis_front #(
    .ADDR_W (ADDR_W),
    .OC_W   (OC_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .sizes     (sizes),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  nnis_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (nnis_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  nnis_back #(
    .ADDR_W      (ADDR_W),
    .OC_W        (OC_W),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .sizes      (sizes),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The back never takes an entry from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("queue popped while empty");

  // An accepted transaction always finds room in the queue.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (q_count != QCNT_W'(nnis_pkg::QUEUE_DEPTH)))
    else $error("transaction accepted into a full queue");

  // A pushed entry is still held, or being taken, in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (q_count != '0))
    else $error("pushed entry lost from the queue");

endmodule

>>> hw/rtl/nnis_fifo.sv
// Small register queue that decouples the front from the back of the scaler.
// Depends on nothing but its parameters.
module nnis_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign rdata = entry_r[rd_ptr_r];

  // Pointer and count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/nnis_front.sv
// Front of the scaler: accepts transactions, classifies them and tags them with positions.
// Depends on nnis_pkg for the size struct, pixel width and item kinds.
module nnis_front #(
  parameter int ADDR_W = 18,
  parameter int OC_W   = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  nnis_pkg::sizes_t                      sizes,
  // in_tdata fields from bit 0: red, green, blue
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [nnis_pkg::PIX_W-1:0]            in_tdata,
  // in_tuser fields from bit 0: operation
  input  logic                                  in_tuser,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [2*OC_W+ADDR_W+nnis_pkg::PIX_W+1:0] q_data
);

  logic [ADDR_W-1:0]               load_pos_r, load_pos_nxt;
  logic [OC_W-1:0]                 out_row_r, out_row_nxt;
  logic [OC_W-1:0]                 out_col_r, out_col_nxt;
  logic [2*nnis_pkg::SZ_IN_W-1:0]  total;
  logic [ADDR_W-1:0]               pos;
  logic [31:0]                     pos_inc;
  logic [31:0]                     col_inc;
  logic [31:0]                     row_inc;
  logic                            col_wrap;
  logic                            row_wrap;
  logic                            frame_end;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Load position: restart at entry zero when it lies beyond the frame.
  assign total   = (2*nnis_pkg::SZ_IN_W)'(sizes.in_width) *
                   (2*nnis_pkg::SZ_IN_W)'(sizes.in_height);
  assign pos     = (32'(load_pos_r) < 32'(total)) ? load_pos_r : '0;
  assign pos_inc = 32'(pos) + 32'd1;

  // Output raster position and end-of-frame flag.
  assign col_inc   = 32'(out_col_r) + 32'd1;
  assign row_inc   = 32'(out_row_r) + 32'd1;
  assign col_wrap  = (col_inc >= 32'(sizes.out_width));
  assign row_wrap  = (row_inc >= 32'(sizes.out_height));
  assign frame_end = col_wrap && row_wrap;

  always_comb begin
    load_pos_nxt = load_pos_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    if (q_push) begin
      if (in_tuser == nnis_pkg::OP_LOAD) begin
        load_pos_nxt = (pos_inc >= 32'(total)) ? '0 : ADDR_W'(pos_inc);
      end else if (col_wrap) begin
        out_col_nxt = '0;
        out_row_nxt = row_wrap ? '0 : OC_W'(row_inc);
      end else begin
        out_col_nxt = OC_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
    end
  end

  // Queue entry from bit 0: kind, pixel, store address, row, column, frame end.
  assign q_data = {frame_end, out_col_r, out_row_r, pos, in_tdata, in_tuser};

endmodule

>>> hw/rtl/nnis_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on nothing but its parameters.
module nnis_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One shift-and-subtract step; the remainder always stays below the divisor.
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign diff    = rem_sh - {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  assign busy = busy_r;
  assign quot = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/nnis_back.sv
// Back of the scaler: frame store, source coordinate division and output register.
// Depends on nnis_pkg and instantiates nnis_div twice.
module nnis_back #(
  parameter int ADDR_W      = 18,
  parameter int OC_W        = 12,
  parameter int STORE_DEPTH = 262144
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  nnis_pkg::sizes_t                         sizes,
  input  logic                                     q_empty,
  input  logic [2*OC_W+ADDR_W+nnis_pkg::PIX_W+1:0] q_data,
  output logic                                     q_pop,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // out_tdata fields from bit 0: out_red, out_green, out_blue
  output logic [nnis_pkg::PIX_W-1:0]               out_tdata,
  output logic                                     out_tlast
);

  localparam int PIX_W  = nnis_pkg::PIX_W;
  localparam int SIN_W  = nnis_pkg::SZ_IN_W;
  localparam int NUM_W  = OC_W + SIN_W;
  localparam int PIX_LO = 1;
  localparam int ADR_LO = PIX_LO + PIX_W;
  localparam int ROW_LO = ADR_LO + ADDR_W;
  localparam int COL_LO = ROW_LO + OC_W;
  localparam int END_B  = COL_LO + OC_W;

  typedef enum logic [5:0] {
    ST_FETCH = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_ADDR  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_OUT   = 6'b100000
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic              kind;
  logic [PIX_W-1:0]  head_pix;
  logic [ADDR_W-1:0] head_addr;
  logic              out_load;
  logic              div_start;
  logic              row_busy;
  logic              col_busy;
  logic [NUM_W-1:0]  row_num;
  logic [NUM_W-1:0]  col_num;
  logic [NUM_W-1:0]  row_quot;
  logic [NUM_W-1:0]  col_quot;
  logic [SIN_W-1:0]  srow_nxt;
  logic [SIN_W-1:0]  scol_nxt;
  logic [2*SIN_W-1:0] addr_full;

  logic [OC_W-1:0]   emit_row_r;
  logic [OC_W-1:0]   emit_col_r;
  logic              emit_last_r;
  logic [SIN_W-1:0]  srow_r;
  logic [SIN_W-1:0]  scol_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PIX_W-1:0]  rd_data_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  logic [PIX_W-1:0]  store_mem [STORE_DEPTH];

  // Queue head fields.
  assign kind      = q_data[0];
  assign head_pix  = q_data[ADR_LO-1:PIX_LO];
  assign head_addr = q_data[ROW_LO-1:ADR_LO];

  assign q_pop     = (state_r == ST_FETCH) && !q_empty;
  assign div_start = (state_r == ST_MUL);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Sequencer: loads retire in the fetch cycle, emits walk through the whole chain.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FETCH: begin
        if (!q_empty && kind == nnis_pkg::OP_EMIT) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (!row_busy && !col_busy) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_FETCH;
        end
      end
      default: state_nxt = ST_FETCH;
    endcase
  end

  // Scaled positions feed the dividers straight from the multipliers.
  assign row_num = NUM_W'(emit_row_r) * NUM_W'(sizes.in_height);
  assign col_num = NUM_W'(emit_col_r) * NUM_W'(sizes.in_width);

  nnis_div #(
    .NUM_W (NUM_W),
    .DEN_W (nnis_pkg::SZ_OUT_W)
  ) u_row_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (row_num),
    .den   (sizes.out_height),
    .busy  (row_busy),
    .quot  (row_quot)
  );

  nnis_div #(
    .NUM_W (NUM_W),
    .DEN_W (nnis_pkg::SZ_OUT_W)
  ) u_col_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (col_num),
    .den   (sizes.out_width),
    .busy  (col_busy),
    .quot  (col_quot)
  );

  // Positions beyond the frame saturate to the last source row or column.
  assign srow_nxt = (row_quot >= NUM_W'(sizes.in_height)) ?
                    sizes.in_height - 1'b1 : row_quot[SIN_W-1:0];
  assign scol_nxt = (col_quot >= NUM_W'(sizes.in_width)) ?
                    sizes.in_width - 1'b1 : col_quot[SIN_W-1:0];

  assign addr_full = (2*SIN_W)'(srow_r) * (2*SIN_W)'(sizes.in_width) +
                     (2*SIN_W)'(scol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers along the emit chain.
  always_ff @(posedge clk) begin
    if (q_pop && kind == nnis_pkg::OP_EMIT) begin
      emit_row_r  <= q_data[COL_LO-1:ROW_LO];
      emit_col_r  <= q_data[END_B-1:COL_LO];
      emit_last_r <= q_data[END_B];
    end
    if (state_r == ST_DIV) begin
      srow_r <= srow_nxt;
      scol_r <= scol_nxt;
    end
    if (state_r == ST_ADDR) begin
      addr_r <= ADDR_W'(addr_full);
    end
    if (out_load) begin
      out_data_r <= rd_data_r;
      out_last_r <= emit_last_r;
    end
  end

  // Frame store: one write port for loads, one registered read port for emits.
  always_ff @(posedge clk) begin
    if (q_pop && kind == nnis_pkg::OP_LOAD) begin
      store_mem[head_addr] <= head_pix;
    end
    rd_data_r <= store_mem[addr_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> dv/nearest_neighbour_image_scaler_core_test.sv
// Self-checking testbench for the nearest-neighbor image scaler core.
// Holds its own model of the frame store and scaling counters and compares every pixel.
// Depends on nnis_pkg and nearest_neighbour_image_scaler_core.
`timescale 1ns / 1ps

module nearest_neighbour_image_scaler_core_test;

  localparam int MAX_IN_DIM   = 512;
  localparam int MAX_OUT_DIM  = 4096;
  localparam int STORE_DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 100;

  // One expected output pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } scaled_pixel_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [nnis_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [nnis_pkg::PIX_W-1:0]      in_tdata = '0;
  logic                            in_tuser = nnis_pkg::OP_LOAD;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [nnis_pkg::PIX_W-1:0]      out_tdata;
  logic                            out_tlast;

  // Model state: size registers as written, store contents and counters.
  int            in_width_reg = 512;
  int            in_height_reg = 512;
  int            out_width_reg = 512;
  int            out_height_reg = 512;
  logic [23:0]   source_pixels [0:STORE_DEPTH-1];
  bit            pixel_loaded [0:STORE_DEPTH-1];
  int            load_position = 0;
  int            out_row = 0;
  int            out_col = 0;
  scaled_pixel_t pending_pixels [$];

  int            error_count = 0;
  int            items_sent = 0;
  int unsigned   cycle_count = 0;
  bit            no_idle = 1'b0;

  nearest_neighbour_image_scaler_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // red, green, blue from bit 0
    .in_tuser    (in_tuser),   // operation
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),  // out_red, out_green, out_blue from bit 0
    .out_tlast   (out_tlast)   // frame_end
  );

  always #5 clk = ~clk;

  // Cycle budget; a hang ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nearest_neighbour_image_scaler_core_test: errors");
      $finish;
    end
  end

  // The receiver stalls at random unless a steady stretch is running.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 17);
  end

  // Printing stops after a while so a badly broken block cannot flood the log.
  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    end
  endtask

  // Size registers are clamped to 1..limit before use.
  function automatic int clamp_dim(input int raw, input int limit);
    if (raw == 0) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  // Store entry that the next output pixel is taken from.
  function automatic int scaled_source_index();
    int iw, ih, ow, oh, srow, scol;
    iw = clamp_dim(in_width_reg, MAX_IN_DIM);
    ih = clamp_dim(in_height_reg, MAX_IN_DIM);
    ow = clamp_dim(out_width_reg, MAX_OUT_DIM);
    oh = clamp_dim(out_height_reg, MAX_OUT_DIM);
    srow = (out_row * ih) / oh;
    scol = (out_col * iw) / ow;
    if (srow >= ih) srow = ih - 1;
    if (scol >= iw) scol = iw - 1;
    return srow * iw + scol;
  endfunction

  // Writes one source pixel; a position left past the frame restarts at entry 0.
  task automatic store_source_pixel(input logic [23:0] pixel);
    int total, pos;
    total = clamp_dim(in_width_reg, MAX_IN_DIM) * clamp_dim(in_height_reg, MAX_IN_DIM);
    pos = (load_position < total) ? load_position : 0;
    source_pixels[pos] = pixel;
    pixel_loaded[pos] = 1'b1;
    pos++;
    load_position = (pos >= total) ? 0 : pos;
  endtask

  // Queues the next output pixel and steps the output counters.
  task automatic predict_scaled_pixel();
    scaled_pixel_t px;
    logic [23:0] pixel;
    bit col_wrap, row_wrap;
    pixel = source_pixels[scaled_source_index()];
    col_wrap = (out_col + 1) >= clamp_dim(out_width_reg, MAX_OUT_DIM);
    row_wrap = (out_row + 1) >= clamp_dim(out_height_reg, MAX_OUT_DIM);
    px.red = pixel[7:0];
    px.green = pixel[15:8];
    px.blue = pixel[23:16];
    px.frame_end = col_wrap && row_wrap;
    pending_pixels.push_back(px);
    if (col_wrap) begin
      out_col = 0;
      out_row = row_wrap ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
  endtask

  // Sends one transaction. Valid stays high afterwards so that back-to-back
  // transactions never lower and raise it in the same step.
  task automatic send_item(input logic op, input logic [23:0] data);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == nnis_pkg::OP_LOAD) store_source_pixel(data);
    else predict_scaled_pixel();
  endtask

  task automatic send_loads(input int count);
    repeat (count) send_item(nnis_pkg::OP_LOAD, 24'($urandom));
  endtask

  // Emits output pixels, loading first whenever the pixel needed is not in the store.
  task automatic send_emits(input int count);
    repeat (count) begin
      while (!pixel_loaded[scaled_source_index()])
        send_item(nnis_pkg::OP_LOAD, 24'($urandom));
      send_item(nnis_pkg::OP_EMIT, 24'($urandom));
    end
  endtask

  // Random mix of loads and emits; an emit that would read an empty entry becomes a load.
  task automatic run_traffic(input int count, input int emit_pct);
    repeat (count) begin
      if ($urandom_range(99) < emit_pct && pixel_loaded[scaled_source_index()])
        send_item(nnis_pkg::OP_EMIT, 24'($urandom));
      else
        send_item(nnis_pkg::OP_LOAD, 24'($urandom));
    end
  endtask

  // Lets every pending pixel arrive and any load in flight retire.
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phase of one register write; select stays high for the next one.
  task automatic write_register(input logic [1:0] index, input int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (index)
      nnis_pkg::REG_IN_WIDTH:   in_width_reg = value & 'h3FF;
      nnis_pkg::REG_IN_HEIGHT:  in_height_reg = value & 'h3FF;
      nnis_pkg::REG_OUT_WIDTH:  out_width_reg = value & 'h1FFF;
      nnis_pkg::REG_OUT_HEIGHT: out_height_reg = value & 'h1FFF;
      default: ;
    endcase
  endtask

  // Reprograms all four size registers once the block has gone quiet.
  task automatic set_sizes(input int iw, input int ih, input int ow, input int oh);
    wait_for_idle();
    write_register(nnis_pkg::REG_IN_WIDTH, iw);
    write_register(nnis_pkg::REG_IN_HEIGHT, ih);
    write_register(nnis_pkg::REG_OUT_WIDTH, ow);
    write_register(nnis_pkg::REG_OUT_HEIGHT, oh);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Source dimension as written: mostly small, sometimes at or past the maximum.
  function automatic int pick_in_dim(input bit wide);
    if (!wide) return $urandom_range(0, 12);
    case ($urandom_range(3))
      0: return 512;
      1: return 1023;
      2: return $urandom_range(513, 1023);
      default: return $urandom_range(300, 512);
    endcase
  endfunction

  function automatic int pick_out_dim();
    case ($urandom_range(19))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(4097, 8191);
      3: return $urandom_range(17, 4096);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // Compare each pixel with the oldest prediction.
  always @(posedge clk) begin : check_results
    scaled_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with none expected", out_tdata, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[7:0] !== want.red)
          report_mismatch("out_red", 24'(out_tdata[7:0]), 24'(want.red));
        if (out_tdata[15:8] !== want.green)
          report_mismatch("out_green", 24'(out_tdata[15:8]), 24'(want.green));
        if (out_tdata[23:16] !== want.blue)
          report_mismatch("out_blue", 24'(out_tdata[23:16]), 24'(want.blue));
        if (out_tlast !== want.frame_end)
          report_mismatch("frame_end", 24'(out_tlast), 24'(want.frame_end));
      end
    end
  end

  // Upscale a 2x2 image to 3x3 with extreme pixel values, ending on the frame flag.
  task automatic test_upscale_frame();
    set_sizes(2, 2, 3, 3);
    send_item(nnis_pkg::OP_LOAD, 24'h000000);
    send_item(nnis_pkg::OP_LOAD, 24'hFFFFFF);
    send_item(nnis_pkg::OP_LOAD, 24'h55AA0F);
    send_item(nnis_pkg::OP_LOAD, 24'hF0A55A);
    repeat (4) begin
      send_item(nnis_pkg::OP_EMIT, 24'hFFFFFF);
      send_item(nnis_pkg::OP_EMIT, 24'h000000);
    end
    send_item(nnis_pkg::OP_EMIT, 24'($urandom));
  endtask

  // Zero sizes act as one and oversized values saturate; the second setting also
  // leaves the column counter past the new width.
  task automatic test_size_saturation();
    set_sizes(0, 1023, 8191, 0);
    send_loads(3);
    send_emits(6);
    set_sizes(1023, 0, 0, 8191);
    send_emits(5);
  endtask

  // Load position and row counter both start past a smaller frame.
  task automatic test_counters_past_frame();
    send_loads(9);
    set_sizes(3, 2, 5, 3);
    send_loads(2);
    send_emits(12);
  endtask

  // Largest and smallest sizes, with partial frames at the large end.
  task automatic test_extreme_sizes();
    set_sizes(512, 512, 4096, 4096);
    send_emits(24);
    set_sizes(1, 1, 1, 1);
    send_emits(4);
    send_loads(2);
    send_emits(2);
    set_sizes(512, 1, 4096, 1);
    send_emits(20);
  endtask

  // Random size settings; most phases load a whole frame, then mix loads and emits.
  task automatic test_random_frames();
    int start_count, phase, iw, ih, total;
    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(7))
        0: begin iw = pick_in_dim(1'b1); ih = $urandom_range(0, 2); end
        1: begin iw = $urandom_range(0, 2); ih = pick_in_dim(1'b1); end
        default: begin iw = pick_in_dim(1'b0); ih = pick_in_dim(1'b0); end
      endcase
      set_sizes(iw, ih, pick_out_dim(), pick_out_dim());
      no_idle = (phase == 2);
      total = clamp_dim(in_width_reg, MAX_IN_DIM) * clamp_dim(in_height_reg, MAX_IN_DIM);
      if (total <= 1024 && $urandom_range(9) < 6) send_loads(total);
      run_traffic($urandom_range(60, 180), $urandom_range(40, 75));
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_upscale_frame();
    test_size_saturation();
    test_counters_past_frame();
    test_extreme_sizes();
    test_random_frames();
    wait_for_idle();
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("nearest_neighbour_image_scaler_core_test: clean");
    end else begin
      $display("nearest_neighbour_image_scaler_core_test: errors");
    end
    $finish;
  end

endmodule
